[hw/rtl/lfu_cache_key_value_store_defines.svh]
// Assertion macros used by the key-value store top level.
`ifndef LFU_CACHE_KEY_VALUE_STORE_DEFINES_SVH
`define LFU_CACHE_KEY_VALUE_STORE_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define LFU_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, disabled while reset is asserted.
`define LFU_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define LFU_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define LFU_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

[hw/rtl/lfu_kvs_pkg.sv]
// Shared constants and types of the LFU key-value store.
package lfu_kvs_pkg;

	localparam int CAPACITY    = 16;
	localparam int COUNT_WIDTH = 16;
	localparam int DATA_W      = 32;
	localparam int CAP_W       = 5;
	localparam int IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int NUM_W       = $clog2(CAPACITY + 1);
	localparam int CMP_W       = (NUM_W > CAP_W) ? NUM_W : CAP_W;
	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

	// Controller states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_COMMIT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic             load;
		logic             scan;
		logic             commit;
		logic [IDX_W-1:0] idx;
	} cmd_t;

endpackage

[hw/rtl/lfu_kvs_ctrl.sv]
// Controller of the key-value store: sequences capture, scan and update of one beat.
module lfu_kvs_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	output logic                m_tvalid,
	input  logic                m_tready,
	output lfu_kvs_pkg::cmd_t   cmd
);

	localparam logic [lfu_kvs_pkg::IDX_W-1:0] LAST_IDX =
		lfu_kvs_pkg::IDX_W'(lfu_kvs_pkg::CAPACITY - 1);

	lfu_kvs_pkg::state_t state_q, state_d;
	logic [lfu_kvs_pkg::IDX_W-1:0] idx_q;
	logic out_valid_q;
	logic out_free;

	// The output register may be loaded when empty or being drained.
	assign out_free = !out_valid_q || m_tready;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lfu_kvs_pkg::ST_IDLE: begin
				if (s_tvalid) state_d = lfu_kvs_pkg::ST_SCAN;
			end
			lfu_kvs_pkg::ST_SCAN: begin
				if (idx_q == LAST_IDX) state_d = lfu_kvs_pkg::ST_COMMIT;
			end
			lfu_kvs_pkg::ST_COMMIT: begin
				if (out_free) state_d = lfu_kvs_pkg::ST_IDLE;
			end
			default: state_d = lfu_kvs_pkg::ST_IDLE;
		endcase
	end

	// Outputs and commands.
	always_comb begin
		s_tready   = 1'b0;
		cmd.load   = 1'b0;
		cmd.scan   = 1'b0;
		cmd.commit = 1'b0;
		cmd.idx    = idx_q;
		unique case (state_q)
			lfu_kvs_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
			end
			lfu_kvs_pkg::ST_SCAN: begin
				cmd.scan = 1'b1;
			end
			lfu_kvs_pkg::ST_COMMIT: begin
				cmd.commit = out_free;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	assign m_tvalid = out_valid_q;

	// State register and scan index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lfu_kvs_pkg::ST_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				idx_q <= '0;
			end else if (cmd.scan) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	// Result valid flag: set by an update, cleared when the beat is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

[hw/rtl/lfu_kvs_dp.sv]
// Datapath of the key-value store: entry storage, serial scan, update and result register.
module lfu_kvs_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  lfu_kvs_pkg::cmd_t                 cmd,
	input  logic                              cap_wr_en,
	input  logic [lfu_kvs_pkg::CAP_W-1:0]     cap_wr_data,
	input  logic                              in_opcode,
	input  logic [lfu_kvs_pkg::DATA_W-1:0]    in_key,
	input  logic [lfu_kvs_pkg::DATA_W-1:0]    in_value,
	output logic                              out_hit,
	output logic [lfu_kvs_pkg::DATA_W-1:0]    out_read_value,
	output logic                              out_evicted,
	output logic [lfu_kvs_pkg::DATA_W-1:0]    out_evicted_key
);

	localparam int N   = lfu_kvs_pkg::CAPACITY;
	localparam int IW  = lfu_kvs_pkg::IDX_W;
	localparam int NW  = lfu_kvs_pkg::NUM_W;
	localparam int CW  = lfu_kvs_pkg::COUNT_WIDTH;
	localparam int DW  = lfu_kvs_pkg::DATA_W;
	localparam int MW  = lfu_kvs_pkg::CMP_W;
	localparam logic [CW-1:0] COUNT_MAX = '1;

	// Configuration and captured input beat.
	logic [lfu_kvs_pkg::CAP_W-1:0] cap_q;
	logic          op_q;
	logic [DW-1:0] key_q;
	logic [DW-1:0] wval_q;

	// Entry store.
	logic [N-1:0]  valid_q;
	logic [DW-1:0] keys_q  [N];
	logic [DW-1:0] vals_q  [N];
	logic [CW-1:0] cnt_q   [N];
	logic [IW-1:0] rank_q  [N];

	// Scan results.
	logic [NW-1:0] nvalid_q;
	logic          found_q;
	logic [IW-1:0] found_slot_q;
	logic [DW-1:0] found_val_q;
	logic [IW-1:0] found_rank_q;
	logic          free_any_q;
	logic [IW-1:0] free_slot_q;
	logic          min_any_q;
	logic [IW-1:0] min_slot_q;
	logic [CW-1:0] min_cnt_q;
	logic [IW-1:0] min_rank_q;
	logic [DW-1:0] min_key_q;

	// Entry under the scan pointer.
	logic          e_valid;
	logic [DW-1:0] e_key;
	logic [CW-1:0] e_cnt;
	logic [IW-1:0] e_rank;
	logic          e_better;

	// Update decisions.
	logic [NW-1:0] cap_eff;
	logic          enabled;
	logic          hit;
	logic          ins;
	logic          ins_free;
	logic          ins_evict;
	logic          promote;
	logic [IW-1:0] slot;
	logic [IW-1:0] old_rank;
	logic [IW-1:0] new_rank;

	assign e_valid = valid_q[cmd.idx];
	assign e_key   = keys_q[cmd.idx];
	assign e_cnt   = cnt_q[cmd.idx];
	assign e_rank  = rank_q[cmd.idx];

	// Lower count wins; equal counts fall back to the older rank.
	assign e_better = e_valid && (!min_any_q || (e_cnt < min_cnt_q) ||
		((e_cnt == min_cnt_q) && (e_rank < min_rank_q)));

	// Effective capacity is limited to the number of physical entries.
	always_comb begin
		if (MW'(cap_q) > MW'(N)) begin
			cap_eff = NW'(N);
		end else begin
			cap_eff = NW'(cap_q);
		end
	end

	assign enabled   = (cap_eff != '0);
	assign hit       = enabled && found_q;
	assign ins       = enabled && !found_q && op_q;
	assign ins_free  = ins && (nvalid_q < cap_eff);
	assign ins_evict = ins && !ins_free;
	assign promote   = hit || ins_evict;
	assign old_rank  = hit ? found_rank_q : min_rank_q;
	assign new_rank  = promote ? IW'(nvalid_q - 1'b1) : IW'(nvalid_q);

	always_comb begin
		if (found_q) begin
			slot = found_slot_q;
		end else if (ins_free) begin
			slot = free_slot_q;
		end else begin
			slot = min_slot_q;
		end
	end

	// Capacity register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= lfu_kvs_pkg::CAP_RESET;
		end else if (cap_wr_en) begin
			cap_q <= cap_wr_data;
		end
	end

	// Valid bits: set when a free slot is filled.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.commit && ins_free) begin
			valid_q[slot] <= 1'b1;
		end
	end

	// Input capture and scan over one entry per cycle.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q       <= in_opcode;
			key_q      <= in_key;
			wval_q     <= in_value;
			nvalid_q   <= '0;
			found_q    <= 1'b0;
			free_any_q <= 1'b0;
			min_any_q  <= 1'b0;
		end else if (cmd.scan) begin
			nvalid_q <= nvalid_q + NW'(e_valid);
			if (e_valid && !found_q && (e_key == key_q)) begin
				found_q      <= 1'b1;
				found_slot_q <= cmd.idx;
				found_val_q  <= vals_q[cmd.idx];
				found_rank_q <= e_rank;
			end
			if (!e_valid && !free_any_q) begin
				free_any_q  <= 1'b1;
				free_slot_q <= cmd.idx;
			end
			if (e_better) begin
				min_any_q  <= 1'b1;
				min_slot_q <= cmd.idx;
				min_cnt_q  <= e_cnt;
				min_rank_q <= e_rank;
				min_key_q  <= e_key;
			end
		end
	end

	// Entry update: value, key, count and recency order.
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			if (promote) begin
				for (int i = 0; i < N; i++) begin
					if (valid_q[i] && (IW'(i) != slot) && (rank_q[i] > old_rank)) begin
						rank_q[i] <= rank_q[i] - 1'b1;
					end
				end
			end
			if (promote || ins_free) begin
				rank_q[slot] <= new_rank;
			end
			if (ins) begin
				keys_q[slot] <= key_q;
				cnt_q[slot]  <= CW'(1);
			end else if (hit && (cnt_q[slot] != COUNT_MAX)) begin
				cnt_q[slot] <= cnt_q[slot] + 1'b1;
			end
			if (ins || (hit && op_q)) begin
				vals_q[slot] <= wval_q;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_hit         <= hit;
			out_read_value  <= (hit && !op_q) ? found_val_q : '1;
			out_evicted     <= ins_evict;
			out_evicted_key <= ins_evict ? min_key_q : '0;
		end
	end

endmodule

[hw/rtl/lfu_cache_key_value_store.sv]
// Top level of the LFU key-value store with least-recent tie break.
//
// Input beats arrive on s_tvalid/s_tready: s_tuser[0] is the opcode (0 get,
// 1 put), s_tdata carries the key and the value to write. Each input beat
// yields exactly one result beat on m_tvalid/m_tready: m_tuser flags a hit
// and an eviction, m_tdata carries the read value and the evicted key.
// The user must write the capacity register with capacity_in_use_wr_en
// only while idle; the block does not enforce this. An item passes through
// capture of the beat, a scan of the store one entry at a time through its
// single read port for the key match, the free slot and the replacement
// candidate, and an update of the store, before the next beat is taken.
// m_tvalid is registered and rises as the controller returns to idle.
// The result sits in an output register, so a new beat is accepted and
// scanned while the previous result waits; if the receiver still stalls at
// the end of that scan, the update holds until the output register frees.
// Reset clears all valid bits and sets the capacity to 16; no clearing
// pass is needed, the block is ready for input as soon as reset is released.
`include "lfu_cache_key_value_store_defines.svh"
module lfu_cache_key_value_store (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        capacity_in_use_wr_en,
	input  logic [4:0]  capacity_in_use_wr_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // key [31:0], write_value [63:32]
	input  logic [0:0]  s_tuser,   // opcode [0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // read_value [31:0], evicted_key [63:32]
	output logic [1:0]  m_tuser    // hit [0], evicted [1]
);

	lfu_kvs_pkg::cmd_t cmd;
	logic out_hit;
	logic out_evicted;

	// Control sequencer.
	lfu_kvs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	// Storage, scan and result datapath.
	lfu_kvs_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.cap_wr_en       (capacity_in_use_wr_en),
		.cap_wr_data     (capacity_in_use_wr_data),
		.in_opcode       (s_tuser[0]),
		.in_key          (s_tdata[31:0]),
		.in_value        (s_tdata[63:32]),
		.out_hit         (out_hit),
		.out_read_value  (m_tdata[31:0]),
		.out_evicted     (out_evicted),
		.out_evicted_key (m_tdata[63:32])
	);

	assign m_tuser = {out_evicted, out_hit};

	// Checks on the sequencing of a beat through the block.
	`LFU_ASSERT_NXT(a_accept_starts_scan, clk, arst_n, s_tvalid && s_tready,
		cmd.scan && (cmd.idx == '0), "accepted beat did not start a scan at entry zero")
	`LFU_ASSERT_IMP(a_commit_out_free, clk, arst_n, cmd.commit,
		!m_tvalid || m_tready, "update would overwrite a result not yet taken")
	`LFU_ASSERT_IMP(a_idle_no_work, clk, arst_n, s_tready,
		!cmd.scan && !cmd.commit, "scan or update issued while ready for input")
	`LFU_ASSERT_NXT(a_commit_gives_result, clk, arst_n, cmd.commit,
		m_tvalid, "update did not present a result beat")

endmodule
